>>> sv/fud_pkg.sv
// Package: shared types, result kind codes and character helpers for the form pair decoder.
package fud_pkg;

    localparam logic [1:0] KIND_NAME     = 2'd0;
    localparam logic [1:0] KIND_VALUE    = 2'd1;
    localparam logic [1:0] KIND_COMPLETE = 2'd2;
    localparam logic [1:0] KIND_DROPPED  = 2'd3;

    localparam logic [1:0] ESC_NONE = 2'd0;
    localparam logic [1:0] ESC_HIGH = 2'd1;
    localparam logic [1:0] ESC_LOW  = 2'd2;

    localparam logic [4:0] HEX_BAD = 5'd16;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [1:0] out_kind;
        logic       message_done;
        logic       stopped_early;
    } result_t;

    typedef struct packed {
        logic       in_value;
        logic [1:0] escape_phase;
        logic [3:0] high_nibble;
        logic       name_nonempty;
        logic       value_nonempty;
        logic       halted;
    } state_t;

    localparam state_t STATE_CLEAR = '{
        in_value:       1'b0,
        escape_phase:   ESC_NONE,
        high_nibble:    4'd0,
        name_nonempty:  1'b0,
        value_nonempty: 1'b0,
        halted:         1'b0
    };

    // Outcome of one byte: next state and up to two results.
    typedef struct packed {
        state_t     state_next;
        logic [1:0] count;
        result_t    res0;
        result_t    res1;
    } step_t;

    function automatic logic is_plain(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") ||
               (c >= "0" && c <= "9") || c == "." || c == "-" ||
               c == "~" || c == "_";
    endfunction

    // 0..15 for an uppercase hex digit, HEX_BAD otherwise.
    function automatic logic [4:0] hex_val(input logic [7:0] c);
        logic [7:0] d;
        d = 8'd0;
        if (c >= "0" && c <= "9")
        begin
            d = c - 8'h30;
            return d[4:0];
        end
        if (c >= "A" && c <= "F")
        begin
            d = c - 8'h37;
            return d[4:0];
        end
        return HEX_BAD;
    endfunction

endpackage

>>> sv/fud_if.sv
// Interfaces: encoded byte channel and decoded result channel.
interface fud_enc_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_content;

    modport source (output valid, output data_byte, output end_of_content, input ready);
    modport sink   (input valid, input data_byte, input end_of_content, output ready);
endinterface

interface fud_dec_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic [1:0] out_kind;
    logic       message_done;
    logic       stopped_early;

    modport source (output valid, output out_byte, output out_kind,
                    output message_done, output stopped_early, input ready);
    modport sink   (input valid, input out_byte, input out_kind,
                    input message_done, input stopped_early, output ready);
endinterface

>>> sv/fud_step.sv
// Per-byte decode logic: next parser state and the results one byte causes.
module fud_step
(
    input  fud_pkg::state_t state,
    input  logic [7:0]      data_byte,
    input  logic            end_of_content,
    output fud_pkg::step_t  step
);

    fud_pkg::state_t  ns;
    fud_pkg::result_t r0;
    fud_pkg::result_t r1;
    fud_pkg::result_t fin;
    logic [1:0]       n;
    logic             bad;
    logic             emit;
    logic [7:0]       emit_byte;
    logic [4:0]       hv;

    always_comb
    begin
        ns        = state;
        r0        = '0;
        r1        = '0;
        fin       = '0;
        n         = 2'd0;
        bad       = 1'b0;
        emit      = 1'b0;
        emit_byte = 8'd0;
        hv        = fud_pkg::hex_val(data_byte);

        if (state.halted)
        begin
            if (end_of_content)
            begin
                ns = fud_pkg::STATE_CLEAR;
            end
        end
        else
        begin
            if (state.escape_phase == fud_pkg::ESC_HIGH)
            begin
                if (hv == fud_pkg::HEX_BAD)
                begin
                    bad = 1'b1;
                end
                else
                begin
                    ns.high_nibble  = hv[3:0];
                    ns.escape_phase = fud_pkg::ESC_LOW;
                    bad             = end_of_content;
                end
            end
            else if (state.escape_phase == fud_pkg::ESC_LOW)
            begin
                if (hv == fud_pkg::HEX_BAD)
                begin
                    bad = 1'b1;
                end
                else
                begin
                    ns.escape_phase = fud_pkg::ESC_NONE;
                    emit            = 1'b1;
                    emit_byte       = {state.high_nibble, hv[3:0]};
                end
            end
            else if (fud_pkg::is_plain(data_byte))
            begin
                emit      = 1'b1;
                emit_byte = data_byte;
            end
            else if (data_byte == "+")
            begin
                emit      = 1'b1;
                emit_byte = 8'h20;
            end
            else if (data_byte == "%")
            begin
                ns.escape_phase = fud_pkg::ESC_HIGH;
                bad             = end_of_content;
            end
            else if (data_byte == "=")
            begin
                ns.in_value = 1'b1;
            end
            else if (data_byte == "&")
            begin
                r0.out_kind       = fud_pkg::KIND_COMPLETE;
                n                 = 2'd1;
                ns.name_nonempty  = 1'b0;
                ns.value_nonempty = 1'b0;
                ns.in_value       = 1'b0;
            end
            else
            begin
                bad = 1'b1;
            end

            if (emit)
            begin
                r0.out_byte = emit_byte;
                r0.out_kind = state.in_value ? fud_pkg::KIND_VALUE : fud_pkg::KIND_NAME;
                n           = 2'd1;
                if (state.in_value)
                begin
                    ns.value_nonempty = 1'b1;
                end
                else
                begin
                    ns.name_nonempty = 1'b1;
                end
            end

            // final marker judges the flags as this byte leaves them
            fin.out_kind      = (ns.name_nonempty && ns.value_nonempty) ?
                                fud_pkg::KIND_COMPLETE : fud_pkg::KIND_DROPPED;
            fin.message_done  = 1'b1;
            fin.stopped_early = bad;

            if (bad || end_of_content)
            begin
                if (n == 2'd0)
                begin
                    r0 = fin;
                end
                else
                begin
                    r1 = fin;
                end
                n = n + 2'd1;
                if (end_of_content)
                begin
                    ns = fud_pkg::STATE_CLEAR;
                end
                else
                begin
                    ns.halted = 1'b1;
                end
            end
        end

        step.state_next = ns;
        step.count      = n;
        step.res0       = r0;
        step.res1       = r1;
    end

endmodule

>>> sv/fud_res_fifo.sv
// Three-entry result queue: takes up to two results a cycle, delivers one.
module fud_res_fifo
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [1:0]       push_count,
    input  fud_pkg::result_t push0,
    input  fud_pkg::result_t push1,
    input  logic             pop,
    output logic [1:0]       count,
    output fud_pkg::result_t head
);

    localparam int DEPTH = 3;
    localparam logic [1:0] LAST_IDX = 2'(DEPTH - 1);

    fud_pkg::result_t mem [DEPTH];
    logic [1:0] rd_reg, rd_next;
    logic [1:0] wr_reg, wr_next;
    logic [1:0] count_reg, count_next;

    function automatic logic [1:0] ptr_inc(input logic [1:0] p);
        return (p == LAST_IDX) ? 2'd0 : p + 2'd1;
    endfunction

    always_comb
    begin
        rd_next    = pop ? ptr_inc(rd_reg) : rd_reg;
        case (push_count)
            2'd1:    wr_next = ptr_inc(wr_reg);
            2'd2:    wr_next = ptr_inc(ptr_inc(wr_reg));
            default: wr_next = wr_reg;
        endcase
        count_next = count_reg + push_count - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_reg    <= 2'd0;
            wr_reg    <= 2'd0;
            count_reg <= 2'd0;
        end
        else
        begin
            rd_reg    <= rd_next;
            wr_reg    <= wr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_count != 2'd0)
        begin
            mem[wr_reg] <= push0;
        end
        if (push_count == 2'd2)
        begin
            mem[ptr_inc(wr_reg)] <= push1;
        end
    end

    assign count = count_reg;
    assign head  = mem[rd_reg];

endmodule

>>> sv/form_urlencoded_pair_decoder_core.sv
// Top level: form-urlencoded pair decoder, encoded bytes in, decoded bytes and markers out.
//
// Usage:
//   encoded: one raw content byte per transaction, end_of_content set on the
//            final byte of a message.
//   decoded: one result per transaction: a name or value byte, or a pair
//            marker (complete / dropped). message_done flags the last result
//            of a message; stopped_early flags an unexpected byte or a mid-escape end.
// Results: each result is written into the result queue when its byte is taken.
// Throughput: one byte per cycle while at most one result waits. A byte yields
//   zero, one or two results; the decoded side drains one result per cycle while
//   the receiver is ready, and only a final byte that decodes a byte or is an '&'
//   yields two. The limit is the single result port draining a three-entry queue.
// encoded.ready depends only on the queue fill (at most one result waiting),
//   never combinationally on decoded.ready.
// Reset: parser state returns to scanning a name with no escape pending and
//   the result queue empties.
// Receiver stall: results wait in the queue; once two are waiting, input
//   transactions are held off until no more than one is waiting.
module form_urlencoded_pair_decoder_core
(
    input  logic            clk,
    input  logic            rst_n,
    fud_enc_if.sink         encoded,
    fud_dec_if.source       decoded
);

    fud_pkg::state_t  state_reg, state_next;
    fud_pkg::step_t   step;
    fud_pkg::result_t head;
    logic [1:0]       fifo_count;
    logic [1:0]       push_count;
    logic             accept;
    logic             pop;

    // parser step for the byte being offered
    fud_step u_step
    (
        .state          (state_reg),
        .data_byte      (encoded.data_byte),
        .end_of_content (encoded.end_of_content),
        .step           (step)
    );

    // room for two more results whenever at most one waits
    assign encoded.ready = (fifo_count <= 2'd1);
    assign accept        = encoded.valid && encoded.ready;
    assign push_count    = accept ? step.count : 2'd0;
    assign pop           = decoded.valid && decoded.ready;

    always_comb
    begin
        state_next = accept ? step.state_next : state_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= fud_pkg::STATE_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    fud_res_fifo u_fifo
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_count (push_count),
        .push0      (step.res0),
        .push1      (step.res1),
        .pop        (pop),
        .count      (fifo_count),
        .head       (head)
    );

    assign decoded.valid         = (fifo_count != 2'd0);
    assign decoded.out_byte      = head.out_byte;
    assign decoded.out_kind      = head.out_kind;
    assign decoded.message_done  = head.message_done;
    assign decoded.stopped_early = head.stopped_early;

endmodule

>>> tb/form_urlencoded_pair_decoder_core_tb.sv
// Testbench for the form-urlencoded pair decoder: directed table plus random messages, scoreboarded.
module form_urlencoded_pair_decoder_core_tb;

    // Run shape
    localparam int RANDOM_ITEMS     = 1500;
    localparam int CYCLE_LIMIT      = 200000;
    localparam int DRAIN_CYCLES     = 16;       // slack for a late stray result
    localparam int LONG_HOLD_AT     = 400;      // results taken before the long receiver hold-off
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int PREDICT          = -1;       // table row: expectation comes from the predictor

    localparam fud_pkg::result_t NO_RESULT = '0;

    // One encoded byte and, optionally, its hand-typed expectation.
    typedef struct {
        logic [7:0]       raw;
        logic             last;
        int               typed;      // PREDICT, or number of typed results (0..2)
        fud_pkg::result_t exp_a;
        fud_pkg::result_t exp_b;
    } feed_row_t;

    logic clk;
    logic rst_n;

    fud_enc_if enc_bus();
    fud_dec_if dec_bus();

    form_urlencoded_pair_decoder_core dut
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .encoded (enc_bus),
        .decoded (dec_bus)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // ------------------------------------------------------------------
    // Decoder prediction: own copy of the parse state
    // ------------------------------------------------------------------
    logic       dec_in_value;
    logic [1:0] dec_esc;
    logic [3:0] dec_nibble;
    logic       dec_have_name;
    logic       dec_have_value;
    logic       dec_halted;

    fud_pkg::result_t awaited_results [$];
    int               failures;
    int               send_calm;
    int               recv_calm;

    function automatic void clear_decoder();
        dec_in_value   = 1'b0;
        dec_esc        = fud_pkg::ESC_NONE;
        dec_nibble     = 4'd0;
        dec_have_name  = 1'b0;
        dec_have_value = 1'b0;
        dec_halted     = 1'b0;
    endfunction

    // A-Z a-z 0-9 . - ~ _
    function automatic logic unreserved(input logic [7:0] c);
        return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") ||
               (c >= "0" && c <= "9") || c == "." || c == "-" || c == "~" || c == "_";
    endfunction

    // Bit 4 set: not an uppercase hex digit.
    function automatic logic [4:0] upper_hex(input logic [7:0] c);
        logic [7:0] v;
        v = 8'd16;
        if (c >= "0" && c <= "9")
        begin
            v = c - "0";
        end
        else if (c >= "A" && c <= "F")
        begin
            v = c - "A" + 8'd10;
        end
        return v[4:0];
    endfunction

    // Name or value byte; marks the current half of the pair as non-empty.
    function automatic fud_pkg::result_t data_result(input logic [7:0] b);
        fud_pkg::result_t r;
        r = '{b, dec_in_value ? fud_pkg::KIND_VALUE : fud_pkg::KIND_NAME, 1'b0, 1'b0};
        if (dec_in_value)
        begin
            dec_have_value = 1'b1;
        end
        else
        begin
            dec_have_name = 1'b1;
        end
        return r;
    endfunction

    // Advances the predicted state by one byte; returns how many results it causes.
    function automatic int decode_form_byte(input logic [7:0] raw, input logic last,
                                            output fud_pkg::result_t lead_res,
                                            output fud_pkg::result_t tail_res);
        fud_pkg::result_t res [2];
        int               n;
        logic             bad;
        logic [4:0]       nib;
        logic [1:0]       close_kind;
        n      = 0;
        bad    = 1'b0;
        res[0] = NO_RESULT;
        res[1] = NO_RESULT;
        if (dec_halted)
        begin
            // swallowed; end of content rearms the parser
            if (last)
            begin
                clear_decoder();
            end
        end
        else
        begin
            case (dec_esc)
                fud_pkg::ESC_HIGH:
                begin
                    nib = upper_hex(raw);
                    if (nib[4])
                    begin
                        bad = 1'b1;
                    end
                    else
                    begin
                        dec_nibble = nib[3:0];
                        dec_esc    = fud_pkg::ESC_LOW;
                        bad        = last;      // content ends mid-escape
                    end
                end
                fud_pkg::ESC_LOW:
                begin
                    nib = upper_hex(raw);
                    if (nib[4])
                    begin
                        bad = 1'b1;
                    end
                    else
                    begin
                        dec_esc = fud_pkg::ESC_NONE;
                        res[n]  = data_result({dec_nibble, nib[3:0]});
                        n       = n + 1;
                    end
                end
                default:
                begin
                    if (unreserved(raw))
                    begin
                        res[n] = data_result(raw);
                        n      = n + 1;
                    end
                    else if (raw == "+")
                    begin
                        res[n] = data_result(8'h20);
                        n      = n + 1;
                    end
                    else if (raw == "%")
                    begin
                        dec_esc = fud_pkg::ESC_HIGH;
                        bad     = last;
                    end
                    else if (raw == "=")
                    begin
                        dec_in_value = 1'b1;
                    end
                    else if (raw == "&")
                    begin
                        res[n]         = '{8'h00, fud_pkg::KIND_COMPLETE, 1'b0, 1'b0};
                        n              = n + 1;
                        dec_have_name  = 1'b0;
                        dec_have_value = 1'b0;
                        dec_in_value   = 1'b0;
                    end
                    else
                    begin
                        bad = 1'b1;
                    end
                end
            endcase
            // final marker: on a stop or at end of content
            if (bad || last)
            begin
                close_kind = (dec_have_name && dec_have_value) ?
                             fud_pkg::KIND_COMPLETE : fud_pkg::KIND_DROPPED;
                res[n]     = '{8'h00, close_kind, 1'b1, bad};
                n          = n + 1;
                if (last)
                begin
                    clear_decoder();
                end
                else
                begin
                    dec_halted = 1'b1;
                end
            end
        end
        lead_res = res[0];
        tail_res = res[1];
        return n;
    endfunction

    // ------------------------------------------------------------------
    // Directed table. Typed rows are obvious by inspection; PREDICT rows
    // go through the predictor like the random part.
    // ------------------------------------------------------------------
    feed_row_t directed_rows [25] = '{
        // junk byte right after reset: stop with nothing decoded
        '{8'h00, 1'b0, 1, '{8'h00, fud_pkg::KIND_DROPPED, 1'b1, 1'b1}, NO_RESULT},
        // swallowed while stopped; end of content rearms
        '{8'hFF, 1'b1, 0, NO_RESULT, NO_RESULT},
        '{"a",   1'b0, 1, '{"a", fud_pkg::KIND_NAME, 1'b0, 1'b0}, NO_RESULT},
        '{"+",   1'b0, 1, '{8'h20, fud_pkg::KIND_NAME, 1'b0, 1'b0}, NO_RESULT},
        // %00: lowest escaped byte
        '{"%",   1'b0, 0, NO_RESULT, NO_RESULT},
        '{"0",   1'b0, 0, NO_RESULT, NO_RESULT},
        '{"0",   1'b0, 1, '{8'h00, fud_pkg::KIND_NAME, 1'b0, 1'b0}, NO_RESULT},
        '{"=",   1'b0, 0, NO_RESULT, NO_RESULT},
        // %FF: highest escaped byte, in the value
        '{"%",   1'b0, 0, NO_RESULT, NO_RESULT},
        '{"F",   1'b0, 0, NO_RESULT, NO_RESULT},
        '{"F",   1'b0, 1, '{8'hFF, fud_pkg::KIND_VALUE, 1'b0, 1'b0}, NO_RESULT},
        '{"&",   1'b0, 1, '{8'h00, fud_pkg::KIND_COMPLETE, 1'b0, 1'b0}, NO_RESULT},
        '{"~",   1'b0, PREDICT, NO_RESULT, NO_RESULT},
        '{"=",   1'b0, PREDICT, NO_RESULT, NO_RESULT},
        // value byte and a complete final marker from one byte
        '{"_",   1'b1, 2, '{"_", fud_pkg::KIND_VALUE, 1'b0, 1'b0},
                          '{8'h00, fud_pkg::KIND_COMPLETE, 1'b1, 1'b0}},
        // ampersand on the last byte: pair marker then dropped final marker
        '{"&",   1'b1, 2, '{8'h00, fud_pkg::KIND_COMPLETE, 1'b0, 1'b0},
                          '{8'h00, fud_pkg::KIND_DROPPED, 1'b1, 1'b0}},
        // content ends right after '%'
        '{"%",   1'b1, 1, '{8'h00, fud_pkg::KIND_DROPPED, 1'b1, 1'b1}, NO_RESULT},
        '{"Z",   1'b0, PREDICT, NO_RESULT, NO_RESULT},
        // lowercase hex inside an escape stops parsing
        '{"%",   1'b0, PREDICT, NO_RESULT, NO_RESULT},
        '{"a",   1'b0, 1, '{8'h00, fud_pkg::KIND_DROPPED, 1'b1, 1'b1}, NO_RESULT},
        '{"z",   1'b1, 0, NO_RESULT, NO_RESULT},
        // content ends after the first hex digit
        '{"%",   1'b0, PREDICT, NO_RESULT, NO_RESULT},
        '{"A",   1'b1, 1, '{8'h00, fud_pkg::KIND_DROPPED, 1'b1, 1'b1}, NO_RESULT},
        '{".",   1'b0, PREDICT, NO_RESULT, NO_RESULT},
        '{"-",   1'b1, PREDICT, NO_RESULT, NO_RESULT}
    };

    // ------------------------------------------------------------------
    // Random messages: mostly well-formed pairs with random content,
    // the rest noise and broken escapes.
    // ------------------------------------------------------------------
    string      plain_set = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789.-~_";
    logic [7:0] msg_bytes [$];
    feed_row_t  random_rows [$];

    function automatic logic [7:0] hex_digit(input logic [3:0] nib);
        return (nib < 4'd10) ? "0" + 8'(nib) : "A" + 8'(nib) - 8'd10;
    endfunction

    function automatic logic [7:0] plain_char();
        return plain_set[$urandom_range(0, plain_set.len() - 1)];
    endfunction

    // One decoded byte worth of encoded text.
    function automatic void push_token();
        int         pick;
        logic [7:0] v;
        pick = $urandom_range(0, 9);
        if (pick < 6)
        begin
            msg_bytes.push_back(plain_char());
        end
        else if (pick == 6)
        begin
            msg_bytes.push_back("+");
        end
        else
        begin
            v = 8'($urandom_range(0, 255));
            msg_bytes.push_back("%");
            msg_bytes.push_back(hex_digit(v[7:4]));
            msg_bytes.push_back(hex_digit(v[3:0]));
        end
    endfunction

    function automatic void push_tokens(input int lo, input int hi);
        int count;
        count = $urandom_range(lo, hi);
        repeat (count) push_token();
    endfunction

    function automatic void build_random_rows();
        int        shape;
        int        pairs;
        feed_row_t row;
        while (random_rows.size() < RANDOM_ITEMS)
        begin
            msg_bytes.delete();
            shape = $urandom_range(0, 99);
            if (shape < 80)
            begin
                // well-formed pairs; occasionally an empty half or missing '='
                pairs = $urandom_range(1, 4);
                for (int p = 0; p < pairs; p++)
                begin
                    if (p > 0)
                    begin
                        msg_bytes.push_back("&");
                    end
                    push_tokens(($urandom_range(0, 9) == 0) ? 0 : 1, 4);
                    if ($urandom_range(0, 9) != 0)
                    begin
                        msg_bytes.push_back("=");
                    end
                    push_tokens(($urandom_range(0, 9) == 0) ? 0 : 1, 4);
                    if ($urandom_range(0, 19) == 0)
                    begin
                        msg_bytes.push_back("=");
                        push_tokens(0, 2);
                    end
                end
                if ($urandom_range(0, 9) == 0)
                begin
                    msg_bytes.push_back("&");
                end
            end
            else if (shape < 90)
            begin
                // noise: any byte value
                repeat ($urandom_range(1, 8))
                begin
                    if ($urandom_range(0, 1) == 0)
                    begin
                        msg_bytes.push_back(plain_char());
                    end
                    else
                    begin
                        msg_bytes.push_back(8'($urandom_range(0, 255)));
                    end
                end
            end
            else
            begin
                // broken escape after a good prefix, then swallowed bytes
                push_tokens(1, 3);
                if ($urandom_range(0, 1) == 0)
                begin
                    msg_bytes.push_back("=");
                    push_tokens(0, 2);
                end
                msg_bytes.push_back("%");
                case ($urandom_range(0, 3))
                    0: msg_bytes.push_back("a" + 8'($urandom_range(0, 5)));
                    1: msg_bytes.push_back(hex_digit(4'($urandom_range(0, 15))));
                    2: ;
                    default:
                    begin
                        msg_bytes.push_back(hex_digit(4'($urandom_range(0, 15))));
                        msg_bytes.push_back(8'($urandom_range(0, 255)));
                    end
                endcase
                repeat ($urandom_range(0, 3)) msg_bytes.push_back(8'($urandom_range(0, 255)));
            end
            if (msg_bytes.size() == 0)
            begin
                msg_bytes.push_back(plain_char());
            end
            foreach (msg_bytes[i])
            begin
                row = '{msg_bytes[i], (i == msg_bytes.size() - 1), PREDICT,
                        NO_RESULT, NO_RESULT};
                random_rows.push_back(row);
            end
        end
    endfunction

    // Idle cycles before the next transaction; calm stretches of zero in between.
    function automatic int draw_gap(inout int calm_left);
        if (calm_left > 0)
        begin
            calm_left = calm_left - 1;
            return 0;
        end
        if ($urandom_range(0, 29) == 0)
        begin
            calm_left = $urandom_range(10, 50);
        end
        return $urandom_range(0, 7);
    endfunction

    // ------------------------------------------------------------------
    // Encoded side: drive at negedge, accept at posedge
    // ------------------------------------------------------------------
    task automatic send_byte(input feed_row_t item);
        int               gap;
        int               n;
        fud_pkg::result_t pa;
        fud_pkg::result_t pb;
        gap = draw_gap(send_calm);
        if (gap > 0)
        begin
            @(negedge clk);
            enc_bus.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        enc_bus.valid          <= 1'b1;
        enc_bus.data_byte      <= item.raw;
        enc_bus.end_of_content <= item.last;
        @(posedge clk);
        while (!enc_bus.ready)
        begin
            @(posedge clk);
        end
        // transaction taken: advance the predictor, queue what it implies
        n = decode_form_byte(item.raw, item.last, pa, pb);
        if (item.typed != PREDICT)
        begin
            n  = item.typed;
            pa = item.exp_a;
            pb = item.exp_b;
        end
        if (n > 0)
        begin
            awaited_results.push_back(pa);
        end
        if (n > 1)
        begin
            awaited_results.push_back(pb);
        end
    endtask

    // ------------------------------------------------------------------
    // Decoded side: field-by-field compare against the oldest expectation
    // ------------------------------------------------------------------
    function automatic void check_result(input fud_pkg::result_t got);
        fud_pkg::result_t want;
        if (awaited_results.size() == 0)
        begin
            $error("unexpected result: out_byte %h out_kind %0d message_done %0d stopped_early %0d",
                   got.out_byte, got.out_kind, got.message_done, got.stopped_early);
            failures++;
            return;
        end
        want = awaited_results.pop_front();
        if (got.out_byte !== want.out_byte)
        begin
            $error("out_byte: expected %h, actual %h", want.out_byte, got.out_byte);
            failures++;
        end
        if (got.out_kind !== want.out_kind)
        begin
            $error("out_kind: expected %0d, actual %0d", want.out_kind, got.out_kind);
            failures++;
        end
        if (got.message_done !== want.message_done)
        begin
            $error("message_done: expected %0d, actual %0d", want.message_done, got.message_done);
            failures++;
        end
        if (got.stopped_early !== want.stopped_early)
        begin
            $error("stopped_early: expected %0d, actual %0d", want.stopped_early,
                   got.stopped_early);
            failures++;
        end
    endfunction

    // Receiver: random hold-off per result, one long hold-off so the
    // result queue fills and encoded.ready drops while bytes keep coming.
    initial
    begin : result_sink
        int               hold;
        int               taken;
        fud_pkg::result_t got;
        dec_bus.ready = 1'b0;
        hold  = 0;
        taken = 0;
        wait (rst_n === 1'b1);
        hold = draw_gap(recv_calm);
        forever
        begin
            @(negedge clk);
            if (hold > 0)
            begin
                dec_bus.ready <= 1'b0;
                hold = hold - 1;
            end
            else
            begin
                dec_bus.ready <= 1'b1;
            end
            @(posedge clk);
            if (dec_bus.valid && dec_bus.ready)
            begin
                got = '{dec_bus.out_byte, dec_bus.out_kind,
                        dec_bus.message_done, dec_bus.stopped_early};
                check_result(got);
                taken++;
                hold = (taken == LONG_HOLD_AT) ? LONG_HOLD_CYCLES : draw_gap(recv_calm);
            end
        end
    end

    // Hard stop if the handshakes ever hang.
    initial
    begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    // ------------------------------------------------------------------
    // Main sequence: reset, directed table, random messages, drain, verdict
    // ------------------------------------------------------------------
    initial
    begin : main_seq
        enc_bus.valid          = 1'b0;
        enc_bus.data_byte      = 8'h00;
        enc_bus.end_of_content = 1'b0;
        rst_n                  = 1'b0;
        failures               = 0;
        send_calm              = 0;
        recv_calm              = 0;
        clear_decoder();
        build_random_rows();

        // hold reset, then release it mid-cycle at a falling edge
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
        begin
            send_byte(directed_rows[i]);
        end
        foreach (random_rows[i])
        begin
            send_byte(random_rows[i]);
        end
        @(negedge clk);
        enc_bus.valid <= 1'b0;

        // wait out every expected result, then watch for strays
        while (awaited_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (failures == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
